[rtl/core/pjs_pkg.sv]
// shared types and constants for the point to segment projection pipeline
// no dependencies
package pjs_pkg;

    localparam int DIV_STEPS  = 16;
    localparam int SQRT_STEPS = 33;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               degen;
        logic               tzero;
        logic               tone;
    } div_side_t;

    typedef struct packed {
        logic [65:0] r;
        logic [64:0] l2;
        logic [15:0] q;
        div_side_t   side;
    } div_work_t;

    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [16:0] t;
        logic        degen;
    } sqrt_side_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [65:0] rad;
        logic [32:0] root;
        sqrt_side_t  side;
    } sqrt_work_t;

endpackage

[rtl/core/point_to_segment_projection_top.sv]
// point to segment projection: t, projected point, distance and threshold flag
// depends on pjs_pkg, pjs_div_cell, pjs_sqrt_cell
// pipeline from input beat to output beat: 4 setup stages, 16 divide cells,
// 5 interpolation and squaring stages, 33 square root cells, 1 output register
// throughput one beat per cycle while out_stall is low; a stall only holds stages that are full
// reset clears every valid bit and max_distance to zero
module point_to_segment_projection_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [32:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] proj_x,
    output logic signed [31:0] proj_y,
    output logic [16:0]        ratio,
    output logic [32:0]        gap,
    output logic               within_res,
    output logic               degenerate
);

    logic [32:0] max_distance_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9, rdyo;

    pjs_pkg::div_side_t  s1_reg, s2_reg, s3_reg;
    logic signed [32:0]  ux_reg, uy_reg;
    logic signed [65:0]  dd_reg, ee_reg, pd_reg, qd_reg;
    logic [64:0]         l2_reg;
    logic signed [65:0]  dot_reg;
    pjs_pkg::div_work_t  w4_reg;
    pjs_pkg::div_work_t  w4_next;

    pjs_pkg::div_work_t  dwork [pjs_pkg::DIV_STEPS+1];
    logic                dvalid [pjs_pkg::DIV_STEPS+1];
    logic                dready [pjs_pkg::DIV_STEPS+1];

    logic [16:0]         t_next;
    logic [16:0]         t5_reg, t6_reg, t7_reg, t8_reg, t9_reg;
    logic                dg5_reg, dg6_reg, dg7_reg, dg8_reg, dg9_reg;
    logic signed [50:0]  prx_reg, pry_reg;
    logic signed [31:0]  px5_reg, py5_reg, sx5_reg, sy5_reg, px6_reg, py6_reg;
    logic signed [51:0]  bx, by;
    logic signed [33:0]  qx6_reg, qy6_reg, qx6_next, qy6_next;
    logic [31:0]         qx7_reg, qy7_reg, qx8_reg, qy8_reg, qx9_reg, qy9_reg;
    logic signed [33:0]  gx7_reg, gy7_reg;
    logic signed [67:0]  gxx_reg, gyy_reg;
    logic [65:0]         s9_reg;
    logic signed [68:0]  ssum;
    pjs_pkg::sqrt_work_t sq_in;

    pjs_pkg::sqrt_work_t swork [pjs_pkg::SQRT_STEPS+1];
    logic                svalid [pjs_pkg::SQRT_STEPS+1];
    logic                sready [pjs_pkg::SQRT_STEPS+1];

    pjs_pkg::sqrt_work_t last_sq;
    logic [32:0]         gap_reg;
    logic                within_reg;

    assign rdyo = !vo_reg || !out_stall;
    assign sready[pjs_pkg::SQRT_STEPS] = rdyo;
    assign rdy9 = !v9_reg || sready[0];
    assign rdy8 = !v8_reg || rdy9;
    assign rdy7 = !v7_reg || rdy8;
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign dready[pjs_pkg::DIV_STEPS] = rdy5;
    assign rdy4 = !v4_reg || dready[0];
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= '0;
        end
        else if (cfg_write)
        begin
            max_distance_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= dvalid[pjs_pkg::DIV_STEPS];
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
            if (rdy8) v8_reg <= v7_reg;
            if (rdy9) v9_reg <= v8_reg;
            if (rdyo) vo_reg <= svalid[pjs_pkg::SQRT_STEPS];
        end
    end

    // setup: differences, products, sums, classification
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_reg.px    <= point_x;
            s1_reg.py    <= point_y;
            s1_reg.sx    <= start_x;
            s1_reg.sy    <= start_y;
            s1_reg.dx    <= 33'(end_x) - 33'(start_x);
            s1_reg.dy    <= 33'(end_y) - 33'(start_y);
            s1_reg.degen <= (end_x == start_x) && (end_y == start_y);
            s1_reg.tzero <= 1'b0;
            s1_reg.tone  <= 1'b0;
            ux_reg       <= 33'(point_x) - 33'(start_x);
            uy_reg       <= 33'(point_y) - 33'(start_y);
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s1_reg;
            dd_reg <= 66'(s1_reg.dx) * 66'(s1_reg.dx);
            ee_reg <= 66'(s1_reg.dy) * 66'(s1_reg.dy);
            pd_reg <= 66'(ux_reg) * 66'(s1_reg.dx);
            qd_reg <= 66'(uy_reg) * 66'(s1_reg.dy);
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg  <= s2_reg;
            l2_reg  <= 65'(dd_reg[63:0]) + 65'(ee_reg[63:0]);
            dot_reg <= pd_reg + qd_reg;
        end
        if (rdy4 && v3_reg)
        begin
            w4_reg <= w4_next;
        end
    end

    always_comb
    begin
        w4_next            = '0;
        w4_next.side       = s3_reg;
        w4_next.l2         = l2_reg;
        w4_next.side.tzero = s3_reg.degen || dot_reg[65] || (dot_reg == '0);
        w4_next.side.tone  = !w4_next.side.tzero && (dot_reg[64:0] >= l2_reg);
        if (!w4_next.side.tzero && !w4_next.side.tone)
        begin
            w4_next.r = {1'b0, dot_reg[64:0]};
        end
    end

    assign dwork[0]  = w4_reg;
    assign dvalid[0] = v4_reg;

    for (genvar i = 0; i < pjs_pkg::DIV_STEPS; i++)
    begin : g_div
        pjs_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dvalid[i]),
            .up_ready (dready[i]),
            .up_work  (dwork[i]),
            .dn_valid (dvalid[i+1]),
            .dn_ready (dready[i+1]),
            .dn_work  (dwork[i+1])
        );
    end

    // interpolation and squared distance
    always_comb
    begin
        priority if (dwork[pjs_pkg::DIV_STEPS].side.tone)
        begin
            t_next = pjs_pkg::ONE_Q16;
        end
        else if (dwork[pjs_pkg::DIV_STEPS].side.tzero)
        begin
            t_next = '0;
        end
        else
        begin
            t_next = {1'b0, dwork[pjs_pkg::DIV_STEPS].q};
        end
        bx       = 52'(prx_reg) + 52'sd32768;
        by       = 52'(pry_reg) + 52'sd32768;
        qx6_next = 34'(sx5_reg) + 34'(bx >>> 16);
        qy6_next = 34'(sy5_reg) + 34'(by >>> 16);
        ssum     = 69'(gxx_reg) + 69'(gyy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && dvalid[pjs_pkg::DIV_STEPS])
        begin
            t5_reg  <= t_next;
            dg5_reg <= dwork[pjs_pkg::DIV_STEPS].side.degen;
            px5_reg <= dwork[pjs_pkg::DIV_STEPS].side.px;
            py5_reg <= dwork[pjs_pkg::DIV_STEPS].side.py;
            sx5_reg <= dwork[pjs_pkg::DIV_STEPS].side.sx;
            sy5_reg <= dwork[pjs_pkg::DIV_STEPS].side.sy;
            prx_reg <= 51'($signed({1'b0, t_next})) * 51'(dwork[pjs_pkg::DIV_STEPS].side.dx);
            pry_reg <= 51'($signed({1'b0, t_next})) * 51'(dwork[pjs_pkg::DIV_STEPS].side.dy);
        end
        if (rdy6 && v5_reg)
        begin
            t6_reg  <= t5_reg;
            dg6_reg <= dg5_reg;
            px6_reg <= px5_reg;
            py6_reg <= py5_reg;
            qx6_reg <= qx6_next;
            qy6_reg <= qy6_next;
        end
        if (rdy7 && v6_reg)
        begin
            t7_reg  <= t6_reg;
            dg7_reg <= dg6_reg;
            qx7_reg <= qx6_reg[31:0];
            qy7_reg <= qy6_reg[31:0];
            gx7_reg <= 34'(px6_reg) - qx6_reg;
            gy7_reg <= 34'(py6_reg) - qy6_reg;
        end
        if (rdy8 && v7_reg)
        begin
            t8_reg  <= t7_reg;
            dg8_reg <= dg7_reg;
            qx8_reg <= qx7_reg;
            qy8_reg <= qy7_reg;
            gxx_reg <= 68'(gx7_reg) * 68'(gx7_reg);
            gyy_reg <= 68'(gy7_reg) * 68'(gy7_reg);
        end
        if (rdy9 && v8_reg)
        begin
            t9_reg  <= t8_reg;
            dg9_reg <= dg8_reg;
            qx9_reg <= qx8_reg;
            qy9_reg <= qy8_reg;
            s9_reg  <= ssum[65:0];
        end
    end

    always_comb
    begin
        sq_in            = '0;
        sq_in.rad        = s9_reg;
        sq_in.side.qx    = qx9_reg;
        sq_in.side.qy    = qy9_reg;
        sq_in.side.t     = t9_reg;
        sq_in.side.degen = dg9_reg;
    end

    assign swork[0]  = sq_in;
    assign svalid[0] = v9_reg;

    for (genvar j = 0; j < pjs_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        pjs_sqrt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (svalid[j]),
            .up_ready (sready[j]),
            .up_work  (swork[j]),
            .dn_valid (svalid[j+1]),
            .dn_ready (sready[j+1]),
            .dn_work  (swork[j+1])
        );
    end

    assign last_sq = swork[pjs_pkg::SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (rdyo && svalid[pjs_pkg::SQRT_STEPS])
        begin
            proj_x     <= last_sq.side.qx;
            proj_y     <= last_sq.side.qy;
            ratio      <= last_sq.side.t;
            degenerate <= last_sq.side.degen;
            gap_reg    <= last_sq.root;
            within_reg <= last_sq.root < max_distance_reg;
        end
    end

    assign out_valid  = vo_reg;
    assign gap        = gap_reg;
    assign within_res = within_reg;

endmodule

[rtl/core/pjs_div_cell.sv]
// one restoring division step producing one quotient bit of t
// depends on pjs_pkg
module pjs_div_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  pjs_pkg::div_work_t up_work,
    output logic               dn_valid,
    input  logic               dn_ready,
    output pjs_pkg::div_work_t dn_work
);

    logic               valid_reg;
    pjs_pkg::div_work_t work_reg;
    pjs_pkg::div_work_t work_next;
    logic [65:0]        shifted;
    logic [65:0]        l2_ext;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

    always_comb
    begin
        shifted   = {up_work.r[64:0], 1'b0};
        l2_ext    = {1'b0, up_work.l2};
        work_next = up_work;
        if (shifted >= l2_ext)
        begin
            work_next.r = shifted - l2_ext;
            work_next.q = {up_work.q[14:0], 1'b1};
        end
        else
        begin
            work_next.r = shifted;
            work_next.q = {up_work.q[14:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

[rtl/core/pjs_sqrt_cell.sv]
// one digit-by-digit square root step producing one root bit
// depends on pjs_pkg
module pjs_sqrt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  pjs_pkg::sqrt_work_t up_work,
    output logic                dn_valid,
    input  logic                dn_ready,
    output pjs_pkg::sqrt_work_t dn_work
);

    logic                valid_reg;
    pjs_pkg::sqrt_work_t work_reg;
    pjs_pkg::sqrt_work_t work_next;
    logic [35:0]         rem_sh;
    logic [35:0]         trial;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

    always_comb
    begin
        rem_sh        = {up_work.rem[33:0], up_work.rad[65:64]};
        trial         = {1'b0, up_work.root, 2'b01};
        work_next     = up_work;
        work_next.rad = {up_work.rad[63:0], 2'b00};
        if (rem_sh >= trial)
        begin
            work_next.rem  = rem_sh - trial;
            work_next.root = {up_work.root[31:0], 1'b1};
        end
        else
        begin
            work_next.rem  = rem_sh;
            work_next.root = {up_work.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

[dv/tb_point_to_segment_projection_top.sv]
// testbench for point_to_segment_projection_top: directed table then random beats,
// every result checked against a behavioral projection predictor
// depends on pjs_pkg and the rtl of point_to_segment_projection_top
`timescale 1ns / 1ps

module tb_point_to_segment_projection_top;

    typedef struct {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic [16:0]        t;
        logic [32:0]        gap_val;
        logic               near;
        logic               degen;
    } proj_res_t;

    typedef struct {
        logic signed [31:0] px, py, sx, sy, ex, ey;
        bit                 known;
        logic [16:0]        t;
        logic               degen;
    } seg_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [32:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] point_x = '0, point_y = '0, start_x = '0, start_y = '0;
    logic signed [31:0] end_x = '0, end_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] proj_x, proj_y;
    logic [16:0]        ratio;
    logic [32:0]        gap;
    logic               within_res, degenerate;

    logic [32:0] threshold = '0;
    proj_res_t   pending_q[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    seg_row_t    rows[$];

    point_to_segment_projection_top u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .proj_x(proj_x), .proj_y(proj_y), .ratio(ratio), .gap(gap),
        .within_res(within_res), .degenerate(degenerate)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("tb_point_to_segment_projection_top failed");
        $finish;
    end

    function automatic logic [32:0] root_floor(logic [65:0] s);
        logic [32:0] r;
        logic [32:0] c;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            c = r | (33'd1 << b);
            if ({33'd0, c} * {33'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic signed [33:0] interp(logic signed [31:0] s,
                                                 logic signed [32:0] d, logic [16:0] t);
        logic signed [63:0] prod;
        logic signed [63:0] q;
        prod = $signed({47'd0, t}) * 64'(d);
        q = (prod + 64'sd32768) >>> 16;
        return 34'(64'(s) + q);
    endfunction

    function automatic proj_res_t project(logic signed [31:0] px, py, sx, sy, ex, ey);
        proj_res_t          r;
        logic signed [32:0] dx, dy;
        logic signed [67:0] dot, len2, rem;
        logic signed [33:0] qx, qy;
        logic signed [34:0] gx, gy;
        logic [65:0]        sq;
        dx = 33'(ex) - 33'(sx);
        dy = 33'(ey) - 33'(sy);
        r.degen = (dx == 0) && (dy == 0);
        r.t = '0;
        qx = 34'(sx);
        qy = 34'(sy);
        if (!r.degen)
        begin
            len2 = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
            dot = (68'(px) - 68'(sx)) * 68'(dx) + (68'(py) - 68'(sy)) * 68'(dy);
            if (dot <= 0)
                r.t = '0;
            else if (dot >= len2)
                r.t = pjs_pkg::ONE_Q16;
            else
            begin
                rem = dot;
                for (int i = 0; i < pjs_pkg::DIV_STEPS; i++)
                begin
                    rem = rem <<< 1;
                    r.t = r.t << 1;
                    if (rem >= len2)
                    begin
                        rem = rem - len2;
                        r.t[0] = 1'b1;
                    end
                end
            end
            qx = interp(sx, dx, r.t);
            qy = interp(sy, dy, r.t);
        end
        gx = 35'(px) - 35'(qx);
        gy = 35'(py) - 35'(qy);
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        sq = 66'(gx) * 66'(gx) + 66'(gy) * 66'(gy);
        r.gap_val = root_floor(sq);
        r.qx = qx[31:0];
        r.qy = qy[31:0];
        r.near = r.gap_val < threshold;
        return r;
    endfunction

    task automatic send_beat(logic signed [31:0] px, py, sx, sy, ex, ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        point_x <= px; point_y <= py; start_x <= sx; start_y <= sy;
        end_x <= ex; end_y <= ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_q.push_back(project(px, py, sx, sy, ex, ey));
        @(negedge clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        while (n < 70)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    task automatic write_threshold(logic [32:0] v);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        threshold = v;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(2000))) - 1000 <<< 16;
            2: return $signed(32'($urandom_range(400000))) - 200000;
            default: return $signed(32'($urandom_range(65535))) - 32768 <<< 10;
        endcase
    endfunction

    task automatic add_row(logic signed [31:0] px, py, sx, sy, ex, ey,
                           bit known, logic [16:0] t, logic degen);
        seg_row_t r;
        r.px = px; r.py = py; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
        r.known = known; r.t = t; r.degen = degen;
        rows.push_back(r);
    endtask

    // receiver stall process
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        proj_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected beat: got proj %h %h", $time, proj_x, proj_y);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (proj_x !== e.qx || proj_y !== e.qy || ratio !== e.t
                    || gap !== e.gap_val || within_res !== e.near
                    || degenerate !== e.degen)
                begin
                    $display("%0t mismatch: expected %h %h t=%h gap=%h w=%b d=%b", $time,
                             e.qx, e.qy, e.t, e.gap_val, e.near, e.degen);
                    $display("%0t             actual %h %h t=%h gap=%h w=%b d=%b", $time,
                             proj_x, proj_y, ratio, gap, within_res, degenerate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        proj_res_t chk;
        logic signed [31:0] sx, sy, ex, ey, px, py;
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_row(0, 0, 0, 0, 0, 0, 1, 17'd0, 1);
        add_row(mx, mx, mn, mn, mn, mn, 1, 17'd0, 1);
        add_row(mn, mn, mx, mx, mx, mx, 1, 17'd0, 1);
        add_row(mn, 0, 0, 0, 32'sh10000, 0, 1, 17'd0, 0);
        add_row(mx, 0, 0, 0, 32'sh10000, 0, 1, pjs_pkg::ONE_Q16, 0);
        add_row(32'sh8000, 32'sh50000, 0, 0, 32'sh10000, 0, 1, 17'h8000, 0);
        add_row(0, 0, mn, mn, mx, mx, 0, 0, 0);
        add_row(mx, mn, mn, mx, mx, mn, 1, pjs_pkg::ONE_Q16, 0);
        add_row(mn, mx, mx, mn, mn, mx, 1, pjs_pkg::ONE_Q16, 0);
        add_row(mx, mx, mx, mn, mn, mx, 0, 0, 0);
        add_row(12345, -6789, -100, 200, 3000, -4000, 0, 0, 0);
        add_row(-1, -1, 1, 1, 2, 2, 1, 17'd0, 0);
        add_row(32'sh00010000, 32'sh00030000, 0, 0, 0, 32'sh00030000, 1,
                pjs_pkg::ONE_Q16, 0);
        add_row(mx, mx, 0, 0, -1, 0, 0, 0, 0);
        add_row(mn, mn, 0, 0, 0, 1, 1, 17'd0, 0);
        for (int i = 0; i < rows.size(); i++)
        begin
            if (rows[i].known)
            begin
                chk = project(rows[i].px, rows[i].py, rows[i].sx, rows[i].sy,
                              rows[i].ex, rows[i].ey);
                if (chk.t !== rows[i].t || chk.degen !== rows[i].degen)
                begin
                    $display("%0t mismatch in table row %0d: expected t=%h d=%b got %h %b",
                             $time, i, rows[i].t, rows[i].degen, chk.t, chk.degen);
                    errors++;
                end
            end
            send_beat(rows[i].px, rows[i].py, rows[i].sx, rows[i].sy,
                      rows[i].ex, rows[i].ey);
        end
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_threshold(33'h1ffffffff);
                1: write_threshold(33'h1);
                2: write_threshold(33'h0_0010_0000);
                3: write_threshold(33'h0_8000_0000);
                4: write_threshold(33'h1_0000_0000);
                default: write_threshold(33'($urandom));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (ph == 1)
                hold_cycles = 150;
            for (int k = 0; k < 190; k++)
            begin
                sx = rand_coord(); sy = rand_coord();
                case ($urandom_range(9))
                    0: begin ex = sx; ey = sy; end
                    1: begin ex = sx + $signed(32'($urandom_range(6))) - 3; ey = sy; end
                    default: begin ex = rand_coord(); ey = rand_coord(); end
                endcase
                px = rand_coord(); py = rand_coord();
                send_beat(px, py, sx, sy, ex, ey);
                if (k == 100)
                begin
                    in_valid <= 1'b0;
                    while (pending_q.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end
        write_threshold(33'd0);
        for (int k = 0; k < 20; k++)
            send_beat(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());
        drain();
        if (errors == 0)
            $display("tb_point_to_segment_projection_top passed");
        else
            $display("tb_point_to_segment_projection_top failed");
        $finish;
    end
endmodule
